// ===== rtl/core/typed_slot_allocator_unit_macros.svh =====
// assertion macros shared by the slot allocator rtl
`ifndef TYPED_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define TYPED_SLOT_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define TSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator check failed");
// next-cycle implication, checked outside reset
`define TSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator check failed");
`else
`define TSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/tsa_pkg.sv =====
// shared constants and types of the typed slot allocator
`default_nettype none

package tsa_pkg;

    // field widths
    localparam int KIND_W = 2;
    localparam int TYPE_W = 4;
    localparam int IDX_W  = 6;
    localparam int PEAK_W = 7;
    localparam int STAT_W = 2;

    // default sizing
    localparam int SLOTS_DEF     = 64;
    localparam int NUM_TYPES_DEF = 14;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_DEFINE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PHI     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_ID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

    // one result item
    typedef struct packed {
        logic [IDX_W-1:0]  out_index;
        logic              out_valid;
        logic              is_temp;
        logic [STAT_W-1:0] status;
        logic [PEAK_W-1:0] high_water;
        logic              temp_flag;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/typed_slot_allocator_unit.sv =====
// top level of the typed slot allocator: sequencer, state memory and result register
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-----------------------------------------------
//  input   | i_valid | o_stall | i_kind i_var_type i_has_uses_left i_slot_*
//  output  | o_valid | i_stall | o_out_index o_out_valid o_is_temp o_status
//          |         |         | o_high_water o_temp_flag
//
//  each item first reads its type's pool entry from the
//  synchronous state memory, then searches, updates and writes it back
//  one item is in flight at a time, so reads never overlap a pending write
//  reset clears the per-entry written flags; every pool then reads as free
//  a new item is taken while a finished result waits in the output register
//  a stalled output holds the write-back stage until the register drains
`default_nettype none
`include "typed_slot_allocator_unit_macros.svh"

module typed_slot_allocator_unit #(
    parameter int SLOTS     = tsa_pkg::SLOTS_DEF,
    parameter int NUM_TYPES = tsa_pkg::NUM_TYPES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [tsa_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [tsa_pkg::TYPE_W-1:0]  i_var_type,
    input  wire logic                        i_has_uses_left,
    input  wire logic [tsa_pkg::IDX_W-1:0]   i_slot_index,
    input  wire logic                        i_slot_valid,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [tsa_pkg::IDX_W-1:0]   o_out_index,
    output logic                             o_out_valid,
    output logic                             o_is_temp,
    output logic      [tsa_pkg::STAT_W-1:0]  o_status,
    output logic      [tsa_pkg::PEAK_W-1:0]  o_high_water,
    output logic                             o_temp_flag
);

    localparam int TYPE_W  = tsa_pkg::TYPE_W;
    localparam int ENTRY_W = SLOTS + tsa_pkg::PEAK_W + 1;
    localparam int ADDR_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam logic [TYPE_W:0] TYPES_LIM = (TYPE_W+1)'(NUM_TYPES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                        r_state;
    logic                        n_state;
    logic [tsa_pkg::KIND_W-1:0]  r_kind;
    logic [TYPE_W-1:0]           r_type;
    logic                        r_uses;
    logic [tsa_pkg::IDX_W-1:0]   r_sidx;
    logic                        r_svalid;
    logic                        r_tok;
    logic                        r_out_valid;
    logic                        n_out_valid;
    tsa_pkg::t_result            r_res;

    logic                        in_acc;
    logic                        out_acc;
    logic                        type_ok;
    logic                        rd_en;
    logic                        load;
    logic                        core_wr;
    logic                        wr_en;
    logic [ENTRY_W-1:0]          rd_entry;
    logic [ENTRY_W-1:0]          wr_entry;
    tsa_pkg::t_result            core_res;

    // handshakes
    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_out_valid && !i_stall;
    assign type_ok = ({1'b0, i_var_type} < TYPES_LIM);
    assign rd_en   = in_acc && type_ok;
    assign load    = (r_state == ST_EXEC) && (!r_out_valid || !i_stall);
    assign wr_en   = load && core_wr;

    // pool state memory
    tsa_pool_mem #(
        .ENTRY_W   (ENTRY_W),
        .NUM_TYPES (NUM_TYPES),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_var_type[ADDR_W-1:0]),
        .o_rd_data (rd_entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_type[ADDR_W-1:0]),
        .i_wr_data (wr_entry)
    );

    // search and update datapath
    tsa_alloc_core #(
        .SLOTS   (SLOTS),
        .ENTRY_W (ENTRY_W)
    ) u_core (
        .i_entry         (rd_entry),
        .i_tok           (r_tok),
        .i_kind          (r_kind),
        .i_has_uses_left (r_uses),
        .i_slot_index    (r_sidx),
        .i_slot_valid    (r_svalid),
        .o_entry         (wr_entry),
        .o_wr_en         (core_wr),
        .o_res           (core_res)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output register occupancy
    always_comb begin
        priority if (load) begin
            n_out_valid = 1'b1;
        end else if (out_acc) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind   <= i_kind;
            r_type   <= i_var_type;
            r_uses   <= i_has_uses_left;
            r_sidx   <= i_slot_index;
            r_svalid <= i_slot_valid;
            r_tok    <= type_ok;
        end
        if (load) begin
            r_res <= core_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_index  = r_res.out_index;
    assign o_out_valid  = r_res.out_valid;
    assign o_is_temp    = r_res.is_temp;
    assign o_status     = r_res.status;
    assign o_high_water = r_res.high_water;
    assign o_temp_flag  = r_res.temp_flag;

    // checks
    `TSA_ASSERT_IMP(a_no_rd_wr_overlap, i_clk, i_rst_n, rd_en, !wr_en)
    `TSA_ASSERT_NXT(a_accept_starts_exec, i_clk, i_rst_n, in_acc, r_state == ST_EXEC)
    `TSA_ASSERT_IMP(a_load_needs_room, i_clk, i_rst_n, load, !r_out_valid || !i_stall)
    `TSA_ASSERT_IMP(a_full_not_valid, i_clk, i_rst_n,
                    r_out_valid && (o_status == tsa_pkg::STAT_FULL), !o_out_valid)
    `TSA_ASSERT_NXT(a_load_fills_out, i_clk, i_rst_n, load, r_out_valid && r_state == ST_IDLE)

endmodule

`default_nettype wire

// ===== rtl/core/tsa_pool_mem.sv =====
// pool state memory: one entry per type, valid bits give the cleared reset value
`default_nettype none

module tsa_pool_mem #(
    parameter int ENTRY_W   = tsa_pkg::SLOTS_DEF + tsa_pkg::PEAK_W + 1,
    parameter int NUM_TYPES = tsa_pkg::NUM_TYPES_DEF,
    parameter int ADDR_W    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rd_en,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    output logic      [ENTRY_W-1:0] o_rd_data,
    input  wire logic               i_wr_en,
    input  wire logic [ADDR_W-1:0]  i_wr_addr,
    input  wire logic [ENTRY_W-1:0] i_wr_data
);

    logic [ENTRY_W-1:0]   r_mem [NUM_TYPES];
    logic [NUM_TYPES-1:0] r_written;
    logic [ENTRY_W-1:0]   r_rd_data;
    logic                 r_rd_ok;

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // per-entry written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_written[i_rd_addr];
            end
        end
    end

    // an unwritten entry reads as all free, zero peak, no temp
    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/core/tsa_alloc_core.sv =====
// allocation datapath: first-free search, slot set/clear, peak and temp update
`default_nettype none

module tsa_alloc_core #(
    parameter int SLOTS   = tsa_pkg::SLOTS_DEF,
    parameter int ENTRY_W = SLOTS + tsa_pkg::PEAK_W + 1
) (
    input  wire logic [ENTRY_W-1:0]              i_entry,
    input  wire logic                            i_tok,
    input  wire logic [tsa_pkg::KIND_W-1:0]      i_kind,
    input  wire logic                            i_has_uses_left,
    input  wire logic [tsa_pkg::IDX_W-1:0]       i_slot_index,
    input  wire logic                            i_slot_valid,
    output logic      [ENTRY_W-1:0]              o_entry,
    output logic                                 o_wr_en,
    output tsa_pkg::t_result                     o_res
);

    localparam int IDX_W  = tsa_pkg::IDX_W;
    localparam int PEAK_W = tsa_pkg::PEAK_W;
    localparam logic [IDX_W:0] SLOTS_LIM = (IDX_W+1)'(SLOTS);

    logic [SLOTS-1:0]  map_q;
    logic [PEAK_W-1:0] peak_q;
    logic              temp_q;
    logic [SLOTS-1:0]  free_bits;
    logic [SLOTS-1:0]  low_free;
    logic [SLOTS-1:0]  clr_mask;
    logic              any_free;
    logic [IDX_W-1:0]  first_idx;
    logic [PEAK_W-1:0] slot_cnt;
    logic [SLOTS-1:0]  map_d;
    logic [PEAK_W-1:0] peak_d;
    logic              temp_d;
    logic              in_pool;
    logic              known_kind;

    assign map_q  = i_entry[SLOTS-1:0];
    assign peak_q = i_entry[SLOTS+PEAK_W-1:SLOTS];
    assign temp_q = i_entry[ENTRY_W-1];

    // lowest free slot as a one-hot, then encoded
    assign free_bits = ~map_q;
    assign any_free  = i_tok && (|free_bits);
    assign low_free  = free_bits & (~free_bits + SLOTS'(1));

    always_comb begin
        first_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (low_free[i]) begin
                first_idx = first_idx | IDX_W'(i);
            end
        end
    end

    assign slot_cnt = {1'b0, first_idx} + PEAK_W'(1);
    assign in_pool  = ({1'b0, i_slot_index} < SLOTS_LIM);

    // decoded kinds
    assign known_kind = (i_kind == tsa_pkg::KIND_DEFINE) || (i_kind == tsa_pkg::KIND_PHI)
                        || (i_kind == tsa_pkg::KIND_RELEASE);

    // release mask for the named slot
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            clr_mask[i] = (IDX_W'(i) == i_slot_index);
        end
    end

    // per-kind update
    always_comb begin
        map_d  = map_q;
        peak_d = peak_q;
        temp_d = temp_q;
        o_res  = '0;
        unique case (i_kind)
            tsa_pkg::KIND_DEFINE, tsa_pkg::KIND_PHI: begin
                if (i_has_uses_left) begin
                    if (!any_free) begin
                        o_res.status = tsa_pkg::STAT_FULL;
                    end else begin
                        map_d           = map_q | low_free;
                        peak_d          = (peak_q < slot_cnt) ? slot_cnt : peak_q;
                        o_res.out_index = first_idx;
                        o_res.out_valid = 1'b1;
                    end
                end else if (i_kind == tsa_pkg::KIND_DEFINE) begin
                    o_res.is_temp = 1'b1;
                    temp_d        = 1'b1;
                end
            end
            tsa_pkg::KIND_RELEASE: begin
                if (i_slot_valid) begin
                    o_res.out_index = i_slot_index;
                    o_res.out_valid = 1'b1;
                end
                if (!i_has_uses_left) begin
                    if (!i_slot_valid) begin
                        o_res.status = tsa_pkg::STAT_BAD_ID;
                    end else if (in_pool) begin
                        map_d = map_q & ~clr_mask;
                    end
                end
            end
            default: begin
            end
        endcase
        // unknown kind reports nothing, so pool fields only for known kinds
        if (i_tok && known_kind) begin
            o_res.high_water = peak_d;
            o_res.temp_flag  = temp_d;
        end
    end

    assign o_wr_en = i_tok && known_kind;
    assign o_entry = {temp_d, peak_d, map_d};

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench of the typed slot allocator with its own pool predictor
`timescale 1ns / 1ps

module testbench;

    localparam int SLOT_COUNT     = tsa_pkg::SLOTS_DEF;
    localparam int NUM_POOLS      = tsa_pkg::NUM_TYPES_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int MAX_REPORTS    = 30;
    localparam int RANDOM_ITEMS   = 1400;

    // the kind code that the block does not decode
    localparam logic [tsa_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [tsa_pkg::KIND_W-1:0] kind;
        logic [tsa_pkg::TYPE_W-1:0] var_type;
        logic                       has_uses_left;
        logic [tsa_pkg::IDX_W-1:0]  slot_index;
        logic                       slot_valid;
    } alloc_req_t;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [tsa_pkg::KIND_W-1:0] i_kind = '0;
    logic [tsa_pkg::TYPE_W-1:0] i_var_type = '0;
    logic i_has_uses_left = 1'b0;
    logic [tsa_pkg::IDX_W-1:0] i_slot_index = '0;
    logic i_slot_valid = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [tsa_pkg::IDX_W-1:0] o_out_index;
    logic o_out_valid;
    logic o_is_temp;
    logic [tsa_pkg::STAT_W-1:0] o_status;
    logic [tsa_pkg::PEAK_W-1:0] o_high_water;
    logic o_temp_flag;

    // predicted pool state
    logic [SLOT_COUNT-1:0]      pool_busy [NUM_POOLS];
    logic [tsa_pkg::PEAK_W-1:0] pool_peak [NUM_POOLS];
    logic                       pool_temp [NUM_POOLS];

    tsa_pkg::t_result pending_results[$];

    int mismatches = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int full_seen = 0;
    int bad_id_seen = 0;
    int temps_seen = 0;
    int idle_cycles = 0;

    // sender pacing
    int  burst_left = 4;
    bit  tx_steady = 1'b0;

    // receiver stall pattern
    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;
    int rx_tick = 0;

    typed_slot_allocator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_var_type      (i_var_type),
        .i_has_uses_left (i_has_uses_left),
        .i_slot_index    (i_slot_index),
        .i_slot_valid    (i_slot_valid),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_index     (o_out_index),
        .o_out_valid     (o_out_valid),
        .o_is_temp       (o_is_temp),
        .o_status        (o_status),
        .o_high_water    (o_high_water),
        .o_temp_flag     (o_temp_flag)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // build one item, cutting each value to its field width
    function automatic alloc_req_t make_req(int unsigned kind, int unsigned vtype,
                                            int unsigned uses, int unsigned idx,
                                            int unsigned valid);
        alloc_req_t req;
        req.kind = tsa_pkg::KIND_W'(kind);
        req.var_type = tsa_pkg::TYPE_W'(vtype);
        req.has_uses_left = 1'(uses);
        req.slot_index = tsa_pkg::IDX_W'(idx);
        req.slot_valid = 1'(valid);
        return req;
    endfunction

    // lowest clear bit of a pool, or -1 when every slot is taken
    function automatic int lowest_free(logic [SLOT_COUNT-1:0] busy);
        int slot;
        slot = -1;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
            if (!busy[i]) slot = i;
        return slot;
    endfunction

    // expected result of one item, updating the predicted pool state
    function automatic tsa_pkg::t_result predict_alloc(alloc_req_t req);
        tsa_pkg::t_result res;
        logic type_ok;
        int slot;
        res = '0;
        type_ok = req.var_type < NUM_POOLS;
        if (req.kind == KIND_UNUSED) return res;
        if (req.kind == tsa_pkg::KIND_DEFINE || req.kind == tsa_pkg::KIND_PHI) begin
            if (req.has_uses_left) begin
                slot = type_ok ? lowest_free(pool_busy[req.var_type]) : -1;
                if (slot < 0) begin
                    res.status = tsa_pkg::STAT_FULL;
                end else begin
                    pool_busy[req.var_type][slot] = 1'b1;
                    if (pool_peak[req.var_type] < slot + 1)
                        pool_peak[req.var_type] = tsa_pkg::PEAK_W'(slot + 1);
                    res.out_index = tsa_pkg::IDX_W'(slot);
                    res.out_valid = 1'b1;
                end
            end else if (req.kind == tsa_pkg::KIND_DEFINE) begin
                res.is_temp = 1'b1;
                if (type_ok) pool_temp[req.var_type] = 1'b1;
            end
        end else begin
            // release: echo the id, free it once no uses remain
            if (req.slot_valid) begin
                res.out_index = req.slot_index;
                res.out_valid = 1'b1;
            end
            if (!req.has_uses_left) begin
                if (!req.slot_valid)
                    res.status = tsa_pkg::STAT_BAD_ID;
                else if (type_ok && req.slot_index < SLOT_COUNT)
                    pool_busy[req.var_type][req.slot_index] = 1'b0;
            end
        end
        if (type_ok) begin
            res.high_water = pool_peak[req.var_type];
            res.temp_flag = pool_temp[req.var_type];
        end
        return res;
    endfunction

    // random busy slot of a pool, or -1 when the pool is empty
    function automatic int pick_busy_slot(int pool);
        int count;
        int pick;
        int found;
        count = 0;
        found = -1;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (pool_busy[pool][i]) count++;
        if (count == 0) return -1;
        pick = $urandom_range(0, count - 1);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (pool_busy[pool][i]) begin
                if (pick == 0) found = i;
                pick--;
            end
        end
        return found;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // drive one item from a falling edge, hold it until taken, then pace the next
    task automatic send_item(alloc_req_t req);
        int gap;
        i_kind <= req.kind;
        i_var_type <= req.var_type;
        i_has_uses_left <= req.has_uses_left;
        i_slot_index <= req.slot_index;
        i_slot_valid <= req.slot_valid;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = tx_steady ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 5) == 0) tx_steady = !tx_steady;
        end
    endtask

    // receiver stall pattern, switching to a random mode after each random-length run
    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:     i_stall <= 1'b0;
            RX_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_stall <= (rx_tick % 3 != 0);
            default:     i_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // predict on each accepted item, check each accepted result
    always @(posedge i_clk) begin
        tsa_pkg::t_result want;
        tsa_pkg::t_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                items_accepted++;
                pending_results.insert(pending_results.size(),
                    predict_alloc(make_req(i_kind, i_var_type, i_has_uses_left,
                                           i_slot_index, i_slot_valid)));
            end
            if (o_valid && !i_stall) begin
                got = '{o_out_index, o_out_valid, o_is_temp, o_status, o_high_water,
                        o_temp_flag};
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 0, 1);
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (want.status == tsa_pkg::STAT_FULL) full_seen++;
                    if (want.status == tsa_pkg::STAT_BAD_ID) bad_id_seen++;
                    if (want.is_temp) temps_seen++;
                    if (got.out_index != want.out_index)
                        report_mismatch("out_index", want.out_index, got.out_index);
                    if (got.out_valid != want.out_valid)
                        report_mismatch("out_valid", want.out_valid, got.out_valid);
                    if (got.is_temp != want.is_temp)
                        report_mismatch("is_temp", want.is_temp, got.is_temp);
                    if (got.status != want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.high_water != want.high_water)
                        report_mismatch("high_water", want.high_water, got.high_water);
                    if (got.temp_flag != want.temp_flag)
                        report_mismatch("temp_flag", want.temp_flag, got.temp_flag);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("typed_slot_allocator_unit: mismatch");
            $finish;
        end
    end

    // every operation, field extremes and the corner cases
    task automatic test_directed_cases();
        send_item(make_req(tsa_pkg::KIND_DEFINE, 0, 1'b1, 63, 1'b1));
        send_item(make_req(tsa_pkg::KIND_PHI, 0, 1'b1, 0, 1'b0));
        send_item(make_req(tsa_pkg::KIND_DEFINE, 13, 1'b1, 0, 1'b0));
        send_item(make_req(tsa_pkg::KIND_DEFINE, 0, 1'b0, 63, 1'b1));
        send_item(make_req(tsa_pkg::KIND_PHI, 0, 1'b0, 0, 1'b0));
        send_item(make_req(tsa_pkg::KIND_PHI, 5, 1'b0, 63, 1'b1));
        // release with and without uses left, valid and invalid ids
        send_item(make_req(tsa_pkg::KIND_RELEASE, 0, 1'b1, 1, 1'b1));
        send_item(make_req(tsa_pkg::KIND_RELEASE, 0, 1'b1, 1, 1'b0));
        send_item(make_req(tsa_pkg::KIND_RELEASE, 0, 1'b0, 1, 1'b1));
        send_item(make_req(tsa_pkg::KIND_RELEASE, 0, 1'b0, 0, 1'b0));
        send_item(make_req(tsa_pkg::KIND_DEFINE, 0, 1'b1, 0, 1'b0));
        // release of a slot that is already free
        send_item(make_req(tsa_pkg::KIND_RELEASE, 0, 1'b0, 63, 1'b1));
        // types past the last pool
        send_item(make_req(tsa_pkg::KIND_DEFINE, 14, 1'b1, 0, 1'b0));
        send_item(make_req(tsa_pkg::KIND_DEFINE, 15, 1'b0, 0, 1'b0));
        send_item(make_req(tsa_pkg::KIND_PHI, 15, 1'b1, 63, 1'b1));
        send_item(make_req(tsa_pkg::KIND_RELEASE, 15, 1'b0, 63, 1'b1));
        send_item(make_req(tsa_pkg::KIND_RELEASE, 14, 1'b0, 7, 1'b0));
        // undecoded kind
        send_item(make_req(KIND_UNUSED, 3, 1'b0, 0, 1'b0));
        send_item(make_req(KIND_UNUSED, 15, 1'b1, 63, 1'b1));
        send_item(make_req(tsa_pkg::KIND_PHI, 13, 1'b0, 42, 1'b1));
        send_item(make_req(tsa_pkg::KIND_RELEASE, 13, 1'b0, 0, 1'b1));
        send_item(make_req(tsa_pkg::KIND_DEFINE, 13, 1'b1, 21, 1'b1));
    endtask

    // fill one pool to the top, overflow it, then reuse freed slots
    task automatic test_pool_exhaustion();
        int pool;
        int slot;
        pool = $urandom_range(0, NUM_POOLS - 1);
        while (pool_busy[pool] != '1)
            send_item(make_req($urandom_range(0, 1) ? tsa_pkg::KIND_PHI : tsa_pkg::KIND_DEFINE,
                pool, 1'b1, $urandom, $urandom));
        repeat (2) send_item(make_req(tsa_pkg::KIND_DEFINE, pool, 1'b1, $urandom, $urandom));
        send_item(make_req(tsa_pkg::KIND_PHI, pool, 1'b1, $urandom, $urandom));
        send_item(make_req(tsa_pkg::KIND_RELEASE, pool, 1'b0, SLOT_COUNT - 1, 1'b1));
        repeat (3) begin
            slot = pick_busy_slot(pool);
            send_item(make_req(tsa_pkg::KIND_RELEASE, pool, 1'b0, slot, 1'b1));
        end
        repeat (5) send_item(make_req(tsa_pkg::KIND_DEFINE, pool, 1'b1, $urandom, $urandom));
    endtask

    // mostly well-formed define and release traffic on a few hot pools
    task automatic test_random_traffic(int count);
        int hot_a;
        int hot_b;
        int pool;
        int roll;
        int grow_pct;
        int free_pct;
        int slot;
        bit growing;
        hot_a = 0;
        hot_b = 0;
        growing = 1'b1;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                hot_a = $urandom_range(0, NUM_POOLS - 1);
                hot_b = $urandom_range(0, 1) ? hot_a : $urandom_range(0, NUM_POOLS - 1);
                growing = ($urandom_range(0, 2) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 70)
                pool = $urandom_range(0, 1) ? hot_a : hot_b;
            else if (roll < 95)
                pool = $urandom_range(0, NUM_POOLS - 1);
            else
                pool = $urandom_range(NUM_POOLS, 15);
            grow_pct = growing ? 55 : 20;
            free_pct = grow_pct + (growing ? 15 : 50);
            roll = $urandom_range(0, 99);
            if (roll < grow_pct) begin
                send_item(make_req($urandom_range(0, 1) ? tsa_pkg::KIND_PHI
                    : tsa_pkg::KIND_DEFINE, pool, 1'b1, $urandom, $urandom));
            end else if (roll < free_pct) begin
                slot = (pool < NUM_POOLS) ? pick_busy_slot(pool) : -1;
                if (slot < 0) slot = $urandom_range(0, SLOT_COUNT - 1);
                send_item(make_req(tsa_pkg::KIND_RELEASE, pool, 1'b0, slot, 1'b1));
            end else begin
                roll = roll - free_pct;
                if (roll < 6)
                    send_item(make_req(tsa_pkg::KIND_RELEASE, pool, 1'b1, $urandom, $urandom));
                else if (roll < 12)
                    send_item(make_req(tsa_pkg::KIND_DEFINE, pool, 1'b0, $urandom, $urandom));
                else if (roll < 16)
                    send_item(make_req(tsa_pkg::KIND_PHI, pool, 1'b0, $urandom, $urandom));
                else if (roll < 21)
                    send_item(make_req(tsa_pkg::KIND_RELEASE, pool, 1'b0, $urandom, 1'b1));
                else if (roll < 26)
                    send_item(make_req(tsa_pkg::KIND_RELEASE, pool, 1'b0, $urandom, 1'b0));
                else
                    send_item(make_req(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom));
            end
        end
    endtask

    initial begin
        for (int t = 0; t < NUM_POOLS; t++) begin
            pool_busy[t] = '0;
            pool_peak[t] = '0;
            pool_temp[t] = 1'b0;
        end

        // reset held, then released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_pool_exhaustion();
        test_random_traffic(RANDOM_ITEMS);

        // drain
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items and %0d results: %0d full pools, %0d bad ids, %0d temps",
                 items_accepted, results_checked, full_seen, bad_id_seen, temps_seen);
        $display("%0d field mismatches found", mismatches);
        if (mismatches == 0)
            $display("typed_slot_allocator_unit: match");
        else
            $display("typed_slot_allocator_unit: mismatch");
        $finish;
    end

endmodule
